/* hw/rtl/fat16_root_directory_lookup_macros.svh */
// Assertion helpers for the checker file.
`ifndef FAT16_ROOT_DIRECTORY_LOOKUP_MACROS_SVH
`define FAT16_ROOT_DIRECTORY_LOOKUP_MACROS_SVH

// Checked at every edge outside reset.
`define F16RDL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define F16RDL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/f16rdl_pkg.sv */
`default_nettype none

package f16rdl_pkg;

  localparam int unsigned NAME_LEN  = 11;
  localparam int unsigned BASE_LEN  = 8;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] MARK_END   = 8'h00;
  localparam logic [7:0] MARK_FREE  = 8'hE5;

  localparam logic [4:0] POS_CLUSTER_LO = 5'd26;
  localparam logic [4:0] POS_CLUSTER_HI = 5'd27;
  localparam logic [4:0] POS_ENTRY_LAST = 5'd31;

  localparam logic [31:0] FIRST_CLUSTER = 32'd2;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned COUNT_W     = 24;
  localparam int unsigned WORD_W      = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_COPIES     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_LENGTH     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_SLOTS       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECTOR_SIZE_LOG2 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLUSTER_SPAN     = 3'd5;

  typedef enum logic [1:0] {
    PH_BASE,
    PH_EXT,
    PH_DONE
  } name_phase_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  // sector size limited to 512..4096 bytes
  function automatic logic [3:0] clamp_log2(input logic [3:0] lg);
    logic [3:0] r;
    if (lg < 4'd9) begin
      r = 4'd9;
    end else if (lg > 4'd12) begin
      r = 4'd12;
    end else begin
      r = lg;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/fat16_root_directory_lookup.sv */
// channel | valid    | stall     | payload
// --------+----------+-----------+-------------------------------------------------
// in      | in_valid | in_stall  | func, data_byte, last
// out     | out_valid| out_stall | found, first_sector, sector_count, file_length
// cfg     | cfg_write| -         | cfg_index, cfg_data
//
// One item per cycle while in_stall is low. Name and scan state update in the
// cycle the item is taken; a result is registered in the address stage (multiplies)
// and in the output register. Synchronous reset restores the register defaults and
// clears the target name to spaces. out_stall backs up into in_stall only once
// both the address stage and the output register hold results.
`default_nettype none

module fat16_root_directory_lookup (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [f16rdl_pkg::WORD_W-1:0]  first_sector,
  output logic [f16rdl_pkg::COUNT_W-1:0] sector_count,
  output logic [f16rdl_pkg::WORD_W-1:0]  file_length,
  input  logic        cfg_write,
  input  logic [f16rdl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [f16rdl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  logic [15:0] reserved_count;
  logic [7:0]  table_copies;
  logic [15:0] table_length;
  logic [15:0] root_slots;
  logic [3:0]  sector_size_log2;
  logic [7:0]  cluster_span;

  // name and scan state
  logic [7:0]  target_name [f16rdl_pkg::NAME_LEN];
  logic [7:0]  target_name_next [f16rdl_pkg::NAME_LEN];
  logic [3:0]  name_pos, name_pos_next;
  f16rdl_pkg::name_phase_t name_phase, name_phase_next;
  logic        name_open, name_open_next;
  logic [4:0]  entry_pos, entry_pos_next;
  logic        match_so_far, match_so_far_next;
  logic        entry_skipped, entry_skipped_next;
  logic [15:0] entry_cluster, entry_cluster_next;
  logic [31:0] entry_size, entry_size_next;
  logic        search_done, search_done_next;
  logic        emit, emit_found;
  logic [31:0] emit_size;

  // address stage
  logic        s1_valid;
  logic        s1_found;
  logic [31:0] s1_size;
  logic [31:0] s1_cluster_term;
  logic [31:0] s1_root_start;

  logic        accept, out_load;
  logic [23:0] copies_prod;
  logic [3:0]  eff_log2;
  logic [20:0] root_bytes;
  logic [20:0] dir_span;
  logic [31:0] size_shift;

  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !out_load;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_count   <= 16'd1;
      table_copies     <= 8'd2;
      table_length     <= 16'd0;
      root_slots       <= 16'd512;
      sector_size_log2 <= 4'd9;
      cluster_span     <= 8'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        f16rdl_pkg::CFG_RESERVED_COUNT:   reserved_count   <= cfg_data;
        f16rdl_pkg::CFG_TABLE_COPIES:     table_copies     <= cfg_data[7:0];
        f16rdl_pkg::CFG_TABLE_LENGTH:     table_length     <= cfg_data;
        f16rdl_pkg::CFG_ROOT_SLOTS:       root_slots       <= cfg_data;
        f16rdl_pkg::CFG_SECTOR_SIZE_LOG2: sector_size_log2 <= cfg_data[3:0];
        f16rdl_pkg::CFG_CLUSTER_SPAN:     cluster_span     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    target_name_next   = target_name;
    name_pos_next      = name_pos;
    name_phase_next    = name_phase;
    name_open_next     = name_open;
    entry_pos_next     = entry_pos;
    match_so_far_next  = match_so_far;
    entry_skipped_next = entry_skipped;
    entry_cluster_next = entry_cluster;
    entry_size_next    = entry_size;
    search_done_next   = search_done;
    emit               = 1'b0;
    emit_found         = 1'b0;
    emit_size          = 32'd0;

    if (accept && !func) begin
      // first character of a new name: clear target, restart the scan
      if (!name_open) begin
        for (int i = 0; i < f16rdl_pkg::NAME_LEN; i++) begin
          target_name_next[i] = f16rdl_pkg::CHAR_SPACE;
        end
        name_pos_next      = 4'd0;
        name_phase_next    = f16rdl_pkg::PH_BASE;
        name_open_next     = 1'b1;
        entry_pos_next     = 5'd0;
        match_so_far_next  = 1'b1;
        entry_skipped_next = 1'b0;
        entry_cluster_next = 16'd0;
        entry_size_next    = 32'd0;
        search_done_next   = 1'b0;
      end
      priority if (data_byte == f16rdl_pkg::CHAR_NUL) begin
        name_phase_next = f16rdl_pkg::PH_DONE;
      end else if (name_phase_next == f16rdl_pkg::PH_BASE) begin
        priority if (data_byte == f16rdl_pkg::CHAR_DOT) begin
          name_phase_next = f16rdl_pkg::PH_EXT;
          name_pos_next   = 4'(f16rdl_pkg::BASE_LEN);
        end else if (name_pos_next < 4'(f16rdl_pkg::BASE_LEN)) begin
          target_name_next[name_pos_next] = f16rdl_pkg::upcase(data_byte);
          name_pos_next = name_pos_next + 4'd1;
        end else begin
          name_phase_next = f16rdl_pkg::PH_DONE;
        end
      end else if (name_phase_next == f16rdl_pkg::PH_EXT) begin
        if (name_pos_next < 4'(f16rdl_pkg::NAME_LEN)) begin
          target_name_next[name_pos_next] = f16rdl_pkg::upcase(data_byte);
          name_pos_next = name_pos_next + 4'd1;
        end
      end else begin
      end
      if (last) begin
        name_open_next = 1'b0;
      end
    end else if (accept && func) begin
      if (!search_done) begin
        if (entry_pos == 5'd0 && data_byte == f16rdl_pkg::MARK_END) begin
          emit             = 1'b1;
          search_done_next = 1'b1;
        end else begin
          if (entry_pos == 5'd0 && data_byte == f16rdl_pkg::MARK_FREE) begin
            entry_skipped_next = 1'b1;
          end
          if (entry_pos < 5'(f16rdl_pkg::NAME_LEN) &&
              data_byte != target_name[entry_pos[3:0]]) begin
            match_so_far_next = 1'b0;
          end
          if (entry_pos == f16rdl_pkg::POS_CLUSTER_LO) begin
            entry_cluster_next[7:0] = data_byte;
          end
          if (entry_pos == f16rdl_pkg::POS_CLUSTER_HI) begin
            entry_cluster_next[15:8] = data_byte;
          end
          // size, little endian, bytes 28..31
          if (entry_pos[4:2] == 3'b111) begin
            entry_size_next[{entry_pos[1:0], 3'b000} +: 8] = data_byte;
          end
          if (entry_pos == f16rdl_pkg::POS_ENTRY_LAST) begin
            if (match_so_far_next && !entry_skipped_next) begin
              emit             = 1'b1;
              emit_found       = 1'b1;
              emit_size        = entry_size_next;
              search_done_next = 1'b1;
            end
            entry_pos_next     = 5'd0;
            match_so_far_next  = 1'b1;
            entry_skipped_next = 1'b0;
          end else begin
            entry_pos_next = entry_pos + 5'd1;
          end
        end
      end
      if (last) begin
        if (!search_done_next) begin
          emit = 1'b1;
        end
        entry_pos_next     = 5'd0;
        match_so_far_next  = 1'b1;
        entry_skipped_next = 1'b0;
        entry_cluster_next = 16'd0;
        entry_size_next    = 32'd0;
        search_done_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < f16rdl_pkg::NAME_LEN; i++) begin
        target_name[i] <= f16rdl_pkg::CHAR_SPACE;
      end
      name_pos      <= 4'd0;
      name_phase    <= f16rdl_pkg::PH_BASE;
      name_open     <= 1'b0;
      entry_pos     <= 5'd0;
      match_so_far  <= 1'b1;
      entry_skipped <= 1'b0;
      entry_cluster <= 16'd0;
      entry_size    <= 32'd0;
      search_done   <= 1'b0;
    end else begin
      target_name   <= target_name_next;
      name_pos      <= name_pos_next;
      name_phase    <= name_phase_next;
      name_open     <= name_open_next;
      entry_pos     <= entry_pos_next;
      match_so_far  <= match_so_far_next;
      entry_skipped <= entry_skipped_next;
      entry_cluster <= entry_cluster_next;
      entry_size    <= entry_size_next;
      search_done   <= search_done_next;
    end
  end

  // address stage: the two products
  assign copies_prod = table_copies * table_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= emit;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_found        <= emit_found;
      s1_size         <= emit_size;
      s1_cluster_term <= 32'(({16'd0, entry_cluster} - f16rdl_pkg::FIRST_CLUSTER) *
                             {24'd0, cluster_span});
      s1_root_start   <= {16'd0, reserved_count} + {8'd0, copies_prod};
    end
  end

  // output stage: sums and shifts
  assign eff_log2   = f16rdl_pkg::clamp_log2(sector_size_log2);
  assign root_bytes = {root_slots, 5'd0};
  assign dir_span   = root_bytes >> eff_log2;
  assign size_shift = s1_size >> eff_log2;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found <= s1_found;
      if (s1_found) begin
        first_sector <= s1_root_start + {11'd0, dir_span} + s1_cluster_term;
        sector_count <= size_shift[23:0] + 24'd1;
        file_length  <= s1_size;
      end else begin
        first_sector <= 32'd0;
        sector_count <= 24'd0;
        file_length  <= 32'd0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/f16rdl_checker.sv */
`default_nettype none

`include "fat16_root_directory_lookup_macros.svh"

module f16rdl_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic found,
  input logic [f16rdl_pkg::WORD_W-1:0]  first_sector,
  input logic [f16rdl_pkg::COUNT_W-1:0] sector_count,
  input logic [f16rdl_pkg::WORD_W-1:0]  file_length
);

  `F16RDL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `F16RDL_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(found) && $stable(first_sector) && $stable(sector_count) && $stable(file_length), "stalled result changed")
  `F16RDL_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !out_valid, "result right after reset")
  // a hit always reads at least one sector; a miss carries zero count
  `F16RDL_ASSERT(a_found_count, out_valid |-> found == (sector_count != 24'd0), "found and sector count disagree")
  `F16RDL_ASSERT(a_miss_zero, out_valid && !found |-> first_sector == 32'd0 && file_length == 32'd0, "miss with nonzero fields")

endmodule

bind fat16_root_directory_lookup f16rdl_checker u_f16rdl_checker (.*);

`default_nettype wire
